// ===== hw/rtl/tpc_pkg.sv =====
// Shared types and constants of the triangle plane clipper.
`timescale 1ns / 1ps
package tpc_pkg;

    localparam int FIELD_W         = 48;
    localparam int TEX_W           = 16;
    localparam int COLOR_W         = 32;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int T_FRAC_BITS_DEF = 14;
    localparam int CFG_IDX_W       = 3;
    localparam int NORMAL_Z_RESET  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_X  = 3'd0,
        REG_POINT_Y  = 3'd1,
        REG_POINT_Z  = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_PASS = 2'd1,
        MODE_ONE  = 2'd2,
        MODE_TWO  = 2'd3
    } clip_mode_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [FIELD_W-1:0] tex_c;
        logic [FIELD_W-1:0] tex_b;
        logic [FIELD_W-1:0] tex_a;
        logic [FIELD_W-1:0] vertex_c;
        logic [FIELD_W-1:0] vertex_b;
        logic [FIELD_W-1:0] vertex_a;
    } clip_in_t;

    typedef struct packed {
        logic               last_piece;
        logic               piece_index;
        logic [COLOR_W-1:0] out_color;
        logic [FIELD_W-1:0] out_tex_c;
        logic [FIELD_W-1:0] out_tex_b;
        logic [FIELD_W-1:0] out_tex_a;
        logic [FIELD_W-1:0] out_vertex_c;
        logic [FIELD_W-1:0] out_vertex_b;
        logic [FIELD_W-1:0] out_vertex_a;
    } clip_out_t;

    // Triangle context carried down the pipeline with the clip decision.
    typedef struct packed {
        logic [2:0][FIELD_W-1:0] vtx;
        logic [2:0][FIELD_W-1:0] tex;
        logic [COLOR_W-1:0]      color;
        clip_mode_t              mode;
        logic [1:0]              in0;
        logic [1:0]              in1;
        logic [1:0]              c1b;
        logic [1:0]              c2a;
        logic [1:0]              c2b;
    } clip_ctx_t;

endpackage

// ===== hw/rtl/triangle_plane_clipper_top.sv =====
// Triangle clipper against a configurable plane: config registers and pipeline.
// The block accepts one triangle per clock while its output register is free, and passes
// it through three distance stages, one classify stage, one divider stage per fraction bit,
// two interpolation stages and the output register. A triangle that is cut into two pieces
// holds the output register until both pieces are taken, stalling the whole pipeline, and
// a receiver that holds m_ready low stalls it too; fully clipped triangles produce no
// transaction. Plane registers should be written only while the pipeline is empty.
`timescale 1ns / 1ps
module triangle_plane_clipper_top #(
    parameter int COORD_WIDTH = tpc_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = tpc_pkg::T_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tpc_pkg::clip_in_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tpc_pkg::clip_out_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_wdata
);
    import tpc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int TB   = T_FRAC_BITS;
    localparam int DW   = 2 * CW + 3;
    localparam int SPAN = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;

    function automatic logic signed [CW-1:0] vlane(input logic [FIELD_W-1:0] w, input int i);
        logic [SPAN-1:0] x;
        x = SPAN'(w);
        return x[i*CW +: CW];
    endfunction

    logic signed [CW-1:0] point_reg [3];
    logic signed [CW-1:0] normal_reg [3];
    logic                 en;

    assign cfg_ready = 1'b1;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg[0]  <= '0;
            point_reg[1]  <= '0;
            point_reg[2]  <= '0;
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= CW'(NORMAL_Z_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_POINT_X:  point_reg[0]  <= cfg_wdata;
                REG_POINT_Y:  point_reg[1]  <= cfg_wdata;
                REG_POINT_Z:  point_reg[2]  <= cfg_wdata;
                REG_NORMAL_X: normal_reg[0] <= cfg_wdata;
                REG_NORMAL_Y: normal_reg[1] <= cfg_wdata;
                REG_NORMAL_Z: normal_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Distances.
    logic                 dv;
    clip_in_t             dd;
    logic signed [DW-1:0] vdist [3];

    tpc_dist #(.CW(CW)) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .point    (point_reg),
        .normal   (normal_reg),
        .out_valid(dv),
        .out_data (dd),
        .vdist    (vdist)
    );

    // Classify and set up both edge divisions.
    logic [2:0] is_in;
    clip_ctx_t  sel;
    logic [DW:0] num1, den1, num2, den2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            is_in[i] = !vdist[i][DW-1];
        end
        sel.vtx   = {dd.vertex_c, dd.vertex_b, dd.vertex_a};
        sel.tex   = {dd.tex_c, dd.tex_b, dd.tex_a};
        sel.color = dd.color;
        sel.mode  = MODE_ONE;
        sel.in0   = 2'd0;
        sel.in1   = 2'd0;
        sel.c1b   = 2'd0;
        sel.c2a   = 2'd0;
        sel.c2b   = 2'd0;
        case (is_in)
            3'b000: sel.mode = MODE_NONE;
            3'b111: sel.mode = MODE_PASS;
            3'b001: begin
                sel.in0 = 2'd0; sel.c1b = 2'd1; sel.c2a = 2'd0; sel.c2b = 2'd2;
            end
            3'b010: begin
                sel.in0 = 2'd1; sel.c1b = 2'd0; sel.c2a = 2'd1; sel.c2b = 2'd2;
            end
            3'b100: begin
                sel.in0 = 2'd2; sel.c1b = 2'd0; sel.c2a = 2'd2; sel.c2b = 2'd1;
            end
            3'b011: begin
                sel.mode = MODE_TWO;
                sel.in0 = 2'd0; sel.in1 = 2'd1; sel.c1b = 2'd2; sel.c2a = 2'd1; sel.c2b = 2'd2;
            end
            3'b101: begin
                sel.mode = MODE_TWO;
                sel.in0 = 2'd0; sel.in1 = 2'd2; sel.c1b = 2'd1; sel.c2a = 2'd2; sel.c2b = 2'd1;
            end
            default: begin
                sel.mode = MODE_TWO;
                sel.in0 = 2'd1; sel.in1 = 2'd2; sel.c1b = 2'd0; sel.c2a = 2'd2; sel.c2b = 2'd0;
            end
        endcase
        // For a real cut the inside distance is >= 0 and the outside one < 0.
        num1 = (DW+1)'(vdist[sel.in0]);
        den1 = (DW+1)'(vdist[sel.in0]) - (DW+1)'(vdist[sel.c1b]);
        num2 = (DW+1)'(vdist[sel.c2a]);
        den2 = (DW+1)'(vdist[sel.c2a]) - (DW+1)'(vdist[sel.c2b]);
    end

    logic        sv_reg;
    clip_ctx_t   sctx_reg;
    logic [DW:0] num1_reg, den1_reg, num2_reg, den2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= 1'b0;
        end else if (en) begin
            sv_reg <= dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sctx_reg <= sel;
            num1_reg <= num1;
            den1_reg <= den1;
            num2_reg <= num2;
            den2_reg <= den2;
        end
    end

    logic          qv;
    clip_ctx_t     qctx;
    logic [TB-1:0] t1, t2;

    tpc_div #(.DW(DW), .TB(TB)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sv_reg),
        .in_ctx   (sctx_reg),
        .num1     (num1_reg),
        .den1     (den1_reg),
        .num2     (num2_reg),
        .den2     (den2_reg),
        .out_valid(qv),
        .out_ctx  (qctx),
        .t1       (t1),
        .t2       (t2)
    );

    // Interpolation of both cut vertices, position and texture lanes.
    logic [1:0]         ia [2];
    logic [1:0]         ib [2];
    logic [TB-1:0]      tt [2];
    logic [FIELD_W-1:0] cut_vtx [2];
    logic [FIELD_W-1:0] cut_tex [2];

    assign ia[0] = qctx.in0;
    assign ib[0] = qctx.c1b;
    assign ia[1] = qctx.c2a;
    assign ib[1] = qctx.c2b;
    assign tt[0] = t1;
    assign tt[1] = t2;

    for (genvar c = 0; c < 2; c++) begin : g_cut
        logic signed [CW-1:0]    rv [3];
        logic signed [TEX_W-1:0] rt [3];

        for (genvar j = 0; j < 3; j++) begin : g_lane
            tpc_lerp #(.W(CW), .TB(TB)) u_vtx (
                .aclk(aclk),
                .en  (en),
                .a   (vlane(qctx.vtx[ia[c]], j)),
                .b   (vlane(qctx.vtx[ib[c]], j)),
                .t   (tt[c]),
                .r   (rv[j])
            );
            tpc_lerp #(.W(TEX_W), .TB(TB)) u_tex (
                .aclk(aclk),
                .en  (en),
                .a   (qctx.tex[ia[c]][j*TEX_W +: TEX_W]),
                .b   (qctx.tex[ib[c]][j*TEX_W +: TEX_W]),
                .t   (tt[c]),
                .r   (rt[j])
            );
        end

        assign cut_vtx[c] = FIELD_W'({rv[2], rv[1], rv[0]});
        assign cut_tex[c] = {rt[2], rt[1], rt[0]};
    end

    logic      lv1_reg, lv2_reg;
    clip_ctx_t lctx1_reg, lctx2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv1_reg <= 1'b0;
            lv2_reg <= 1'b0;
        end else if (en) begin
            lv1_reg <= qv;
            lv2_reg <= lv1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lctx1_reg <= qctx;
            lctx2_reg <= lctx1_reg;
        end
    end

    tpc_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(lv2_reg),
        .in_ctx  (lctx2_reg),
        .cut_vtx (cut_vtx),
        .cut_tex (cut_tex),
        .en      (en),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== hw/rtl/tpc_dist.sv =====
// Signed plane distance of the three vertices, three register stages.
`timescale 1ns / 1ps
module tpc_dist #(
    parameter int CW = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  tpc_pkg::clip_in_t     in_data,
    input  logic signed [CW-1:0]  point [3],
    input  logic signed [CW-1:0]  normal [3],
    output logic                  out_valid,
    output tpc_pkg::clip_in_t     out_data,
    output logic signed [2*CW+2:0] vdist [3]
);
    import tpc_pkg::*;

    localparam int PW   = 2 * CW;
    localparam int SW   = 2 * CW + 2;
    localparam int DW   = 2 * CW + 3;
    localparam int SPAN = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;

    function automatic logic signed [CW-1:0] lane(input logic [FIELD_W-1:0] w, input int i);
        logic [SPAN-1:0] x;
        x = SPAN'(w);
        return x[i*CW +: CW];
    endfunction

    logic                 va_reg, vb_reg, vc_reg;
    clip_in_t             da_reg, db_reg, dc_reg;
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [PW-1:0] off_prod_reg [3];
    logic signed [SW-1:0] dot_reg [3];
    logic signed [SW-1:0] off_reg;
    logic signed [DW-1:0] dist_reg [3];
    logic [FIELD_W-1:0]   vw [3];

    assign vw[0] = in_data.vertex_a;
    assign vw[1] = in_data.vertex_b;
    assign vw[2] = in_data.vertex_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            da_reg <= in_data;
            db_reg <= da_reg;
            dc_reg <= db_reg;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= normal[j] * lane(vw[i], j);
                end
                off_prod_reg[i] <= normal[i] * point[i];
                dot_reg[i] <= SW'(prod_reg[i][0]) + SW'(prod_reg[i][1])
                            + SW'(prod_reg[i][2]);
                dist_reg[i] <= DW'(dot_reg[i]) - DW'(off_reg);
            end
            off_reg <= SW'(off_prod_reg[0]) + SW'(off_prod_reg[1]) + SW'(off_prod_reg[2]);
        end
    end

    assign out_valid = vc_reg;
    assign out_data  = dc_reg;
    assign vdist     = dist_reg;

endmodule

// ===== hw/rtl/tpc_div.sv =====
// Two restoring dividers for the edge cut fractions, one quotient bit per stage.
`timescale 1ns / 1ps
module tpc_div #(
    parameter int DW = 35,
    parameter int TB = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  tpc_pkg::clip_ctx_t in_ctx,
    input  logic [DW:0]        num1,
    input  logic [DW:0]        den1,
    input  logic [DW:0]        num2,
    input  logic [DW:0]        den2,
    output logic               out_valid,
    output tpc_pkg::clip_ctx_t out_ctx,
    output logic [TB-1:0]      t1,
    output logic [TB-1:0]      t2
);
    import tpc_pkg::*;

    logic          vld_s  [TB];
    clip_ctx_t     ctx_s  [TB];
    logic [DW:0]   rem1_s [TB];
    logic [DW:0]   den1_s [TB];
    logic [DW:0]   rem2_s [TB];
    logic [DW:0]   den2_s [TB];
    logic [TB-1:0] q1_s   [TB];
    logic [TB-1:0] q2_s   [TB];

    for (genvar k = 0; k < TB; k++) begin : g_step
        logic          vld_in;
        clip_ctx_t     ctx_in;
        logic [DW:0]   r1_in, d1_in, r2_in, d2_in;
        logic [TB-1:0] q1_in, q2_in;
        logic [DW+1:0] sh1, sh2;
        logic          ge1, ge2;
        logic          vld_reg;
        clip_ctx_t     ctx_reg;
        logic [DW:0]   rem1_reg, den1_reg, rem2_reg, den2_reg;
        logic [TB-1:0] q1_reg, q2_reg;

        if (k == 0) begin : g_first
            assign vld_in = in_valid;
            assign ctx_in = in_ctx;
            assign r1_in  = num1;
            assign d1_in  = den1;
            assign r2_in  = num2;
            assign d2_in  = den2;
            assign q1_in  = '0;
            assign q2_in  = '0;
        end else begin : g_next
            assign vld_in = vld_s[k-1];
            assign ctx_in = ctx_s[k-1];
            assign r1_in  = rem1_s[k-1];
            assign d1_in  = den1_s[k-1];
            assign r2_in  = rem2_s[k-1];
            assign d2_in  = den2_s[k-1];
            assign q1_in  = q1_s[k-1];
            assign q2_in  = q2_s[k-1];
        end

        assign sh1 = {r1_in, 1'b0};
        assign sh2 = {r2_in, 1'b0};
        assign ge1 = sh1 >= {1'b0, d1_in};
        assign ge2 = sh2 >= {1'b0, d2_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_reg  <= ctx_in;
                den1_reg <= d1_in;
                den2_reg <= d2_in;
                rem1_reg <= ge1 ? (DW+1)'(sh1 - {1'b0, d1_in}) : (DW+1)'(sh1);
                rem2_reg <= ge2 ? (DW+1)'(sh2 - {1'b0, d2_in}) : (DW+1)'(sh2);
                q1_reg   <= {q1_in[TB-2:0], ge1};
                q2_reg   <= {q2_in[TB-2:0], ge2};
            end
        end

        assign vld_s[k]  = vld_reg;
        assign ctx_s[k]  = ctx_reg;
        assign rem1_s[k] = rem1_reg;
        assign den1_s[k] = den1_reg;
        assign rem2_s[k] = rem2_reg;
        assign den2_s[k] = den2_reg;
        assign q1_s[k]   = q1_reg;
        assign q2_s[k]   = q2_reg;
    end

    assign out_valid = vld_s[TB-1];
    assign out_ctx   = ctx_s[TB-1];
    assign t1        = q1_s[TB-1];
    assign t2        = q2_s[TB-1];

endmodule

// ===== hw/rtl/tpc_lerp.sv =====
// One interpolated lane a + round((b - a) * t), multiply and round in two stages.
`timescale 1ns / 1ps
module tpc_lerp #(
    parameter int W  = 16,
    parameter int TB = 14
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic [TB-1:0]       t,
    output logic signed [W-1:0] r
);
    localparam int PW = W + TB + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (TB - 1);

    logic signed [W:0]    diff;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] shifted;
    logic signed [W-1:0]  a_reg;
    logic signed [W-1:0]  r_reg;

    assign diff    = (W+1)'(b) - (W+1)'(a);
    assign rnd     = prod_reg + HALF;
    assign shifted = rnd >>> TB;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= diff * $signed({1'b0, t});
            a_reg    <= a;
            r_reg    <= a_reg + W'(shifted);
        end
    end

    assign r = r_reg;

endmodule

// ===== hw/rtl/tpc_emit.sv =====
// Output register that sends one or two triangles per input, or none for a fully clipped one.
`timescale 1ns / 1ps
module tpc_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  tpc_pkg::clip_ctx_t          in_ctx,
    input  logic [tpc_pkg::FIELD_W-1:0] cut_vtx [2],
    input  logic [tpc_pkg::FIELD_W-1:0] cut_tex [2],
    output logic                        en,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tpc_pkg::clip_out_t          m_data
);
    import tpc_pkg::*;

    logic               p_valid_reg;
    clip_ctx_t          p_ctx_reg;
    logic [FIELD_W-1:0] p_cv_reg [2];
    logic [FIELD_W-1:0] p_ct_reg [2];
    logic               piece_reg;
    logic               last;
    logic               consume;

    assign last    = (p_ctx_reg.mode != MODE_TWO) || piece_reg;
    assign consume = p_valid_reg && ((p_ctx_reg.mode == MODE_NONE) || (m_ready && last));
    assign en      = !p_valid_reg || consume;
    assign m_valid = p_valid_reg && (p_ctx_reg.mode != MODE_NONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            piece_reg   <= 1'b0;
        end else begin
            if (en) begin
                p_valid_reg <= in_valid;
            end
            if (m_valid && m_ready) begin
                piece_reg <= !last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_ctx_reg <= in_ctx;
            p_cv_reg  <= cut_vtx;
            p_ct_reg  <= cut_tex;
        end
    end

    always_comb begin
        m_data             = '0;
        m_data.out_color   = p_ctx_reg.color;
        m_data.piece_index = piece_reg;
        m_data.last_piece  = last;
        case (p_ctx_reg.mode)
            MODE_ONE: begin
                m_data.out_vertex_a = p_ctx_reg.vtx[p_ctx_reg.in0];
                m_data.out_tex_a    = p_ctx_reg.tex[p_ctx_reg.in0];
                m_data.out_vertex_b = p_cv_reg[0];
                m_data.out_tex_b    = p_ct_reg[0];
                m_data.out_vertex_c = p_cv_reg[1];
                m_data.out_tex_c    = p_ct_reg[1];
            end
            MODE_TWO: begin
                if (piece_reg) begin
                    m_data.out_vertex_a = p_ctx_reg.vtx[p_ctx_reg.in1];
                    m_data.out_tex_a    = p_ctx_reg.tex[p_ctx_reg.in1];
                    m_data.out_vertex_b = p_cv_reg[0];
                    m_data.out_tex_b    = p_ct_reg[0];
                    m_data.out_vertex_c = p_cv_reg[1];
                    m_data.out_tex_c    = p_ct_reg[1];
                end else begin
                    m_data.out_vertex_a = p_ctx_reg.vtx[p_ctx_reg.in0];
                    m_data.out_tex_a    = p_ctx_reg.tex[p_ctx_reg.in0];
                    m_data.out_vertex_b = p_ctx_reg.vtx[p_ctx_reg.in1];
                    m_data.out_tex_b    = p_ctx_reg.tex[p_ctx_reg.in1];
                    m_data.out_vertex_c = p_cv_reg[0];
                    m_data.out_tex_c    = p_ct_reg[0];
                end
            end
            default: begin
                m_data.out_vertex_a = p_ctx_reg.vtx[0];
                m_data.out_vertex_b = p_ctx_reg.vtx[1];
                m_data.out_vertex_c = p_ctx_reg.vtx[2];
                m_data.out_tex_a    = p_ctx_reg.tex[0];
                m_data.out_tex_b    = p_ctx_reg.tex[1];
                m_data.out_tex_c    = p_ctx_reg.tex[2];
            end
        endcase
    end

endmodule

// ===== hw/rtl/tpc_checker.sv =====
// Port-level checks of the clipper's result sequencing, bound to the top level.
`timescale 1ns / 1ps
module tpc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input tpc_pkg::clip_out_t m_data
);
    import tpc_pkg::*;

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The second piece of a triangle is always its last.
    a_second_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.piece_index |-> m_data.last_piece)
        else $error("second piece not marked last");

    // A first piece that is not last is followed at once by the second piece.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_piece |=> m_valid && m_data.piece_index)
        else $error("second piece missing");

    // After a last piece the next triangle starts at piece zero.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_piece |=> !m_valid || !m_data.piece_index)
        else $error("piece index not restarted");

endmodule

bind triangle_plane_clipper_top tpc_checker u_tpc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

// ===== sim/tb_triangle_plane_clipper_top.sv =====
// Testbench for the triangle plane clipper: directed and random triangles checked against a predictor.
`timescale 1ns / 1ps
module tb_triangle_plane_clipper_top;
    import tpc_pkg::*;

    localparam int CW   = COORD_WIDTH_DEF;
    localparam int TFB  = T_FRAC_BITS_DEF;
    localparam int DRAIN = TFB + 20;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    clip_in_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    clip_out_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CW-1:0]    cfg_wdata = '0;

    triangle_plane_clipper_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Plane registers as the predictor sees them.
    logic signed [CW-1:0] plane_pt [3];
    logic signed [CW-1:0] plane_nrm [3];

    clip_out_t pieces_due [$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        mismatches = 0;
    int        pieces_seen = 0;
    int        tris_sent = 0;
    int        split_count = 0;
    int        drop_count = 0;

    function automatic longint signed coord_lane(logic [47:0] w, int i);
        logic [CW-1:0] l;
        l = w[i*CW +: CW];
        return longint'(signed'(l));
    endfunction

    function automatic longint signed tex_lane(logic [47:0] w, int i);
        logic [TEX_W-1:0] l;
        l = w[i*TEX_W +: TEX_W];
        return longint'(signed'(l));
    endfunction

    function automatic longint signed plane_dist(logic [47:0] v);
        longint signed acc;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += longint'(plane_nrm[i]) * (coord_lane(v, i) - longint'(plane_pt[i]));
        return acc;
    endfunction

    // Edge fraction dIn / (dIn - dOut), truncated, as an unsigned TFB-bit fraction.
    function automatic longint signed edge_fraction(longint signed din, longint signed dout);
        longint signed den, rem, q;
        den = din - dout;
        rem = din;
        q = 0;
        if (den <= 0 || rem <= 0) return 0;
        if (rem >= den) return longint'(1) << TFB;
        for (int i = 0; i < TFB; i++) begin
            rem = rem <<< 1;
            q = q <<< 1;
            if (rem >= den) begin
                rem -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic logic [47:0] blend(logic [47:0] a, logic [47:0] b,
                                          longint signed t, bit is_tex);
        logic [47:0]   r;
        longint signed la, lb, p, s;
        int            w;
        r = '0;
        w = is_tex ? TEX_W : CW;
        for (int i = 0; i < 3; i++) begin
            la = is_tex ? tex_lane(a, i) : coord_lane(a, i);
            lb = is_tex ? tex_lane(b, i) : coord_lane(b, i);
            p = (lb - la) * t + (longint'(1) << (TFB - 1));
            s = la + (p >>> TFB);
            for (int k = 0; k < w; k++)
                if (i*w + k < 48) r[i*w + k] = s[k];
        end
        return r;
    endfunction

    task automatic predict_pieces(input clip_in_t trng);
        logic [47:0]   vv [3];
        logic [47:0]   tt [3];
        longint signed d [3];
        int            ins [$];
        int            outs [$];
        clip_out_t     o;
        longint signed t1, t2;
        logic [47:0]   cv1, ct1;
        vv[0] = trng.vertex_a; vv[1] = trng.vertex_b; vv[2] = trng.vertex_c;
        tt[0] = trng.tex_a;    tt[1] = trng.tex_b;    tt[2] = trng.tex_c;
        for (int i = 0; i < 3; i++) begin
            d[i] = plane_dist(vv[i]);
            if (d[i] >= 0) ins.push_back(i);
            else outs.push_back(i);
        end
        o = '0;
        o.out_color = trng.color;
        o.last_piece = 1'b1;
        if (ins.size() == 0) begin
            drop_count++;
        end else if (ins.size() == 3) begin
            o.out_vertex_a = vv[0]; o.out_vertex_b = vv[1]; o.out_vertex_c = vv[2];
            o.out_tex_a = tt[0];    o.out_tex_b = tt[1];    o.out_tex_c = tt[2];
            pieces_due.push_back(o);
        end else if (ins.size() == 1) begin
            t1 = edge_fraction(d[ins[0]], d[outs[0]]);
            t2 = edge_fraction(d[ins[0]], d[outs[1]]);
            o.out_vertex_a = vv[ins[0]];
            o.out_tex_a = tt[ins[0]];
            o.out_vertex_b = blend(vv[ins[0]], vv[outs[0]], t1, 1'b0);
            o.out_tex_b = blend(tt[ins[0]], tt[outs[0]], t1, 1'b1);
            o.out_vertex_c = blend(vv[ins[0]], vv[outs[1]], t2, 1'b0);
            o.out_tex_c = blend(tt[ins[0]], tt[outs[1]], t2, 1'b1);
            pieces_due.push_back(o);
        end else begin
            split_count++;
            t1 = edge_fraction(d[ins[0]], d[outs[0]]);
            t2 = edge_fraction(d[ins[1]], d[outs[0]]);
            cv1 = blend(vv[ins[0]], vv[outs[0]], t1, 1'b0);
            ct1 = blend(tt[ins[0]], tt[outs[0]], t1, 1'b1);
            o.out_vertex_a = vv[ins[0]]; o.out_tex_a = tt[ins[0]];
            o.out_vertex_b = vv[ins[1]]; o.out_tex_b = tt[ins[1]];
            o.out_vertex_c = cv1;        o.out_tex_c = ct1;
            o.last_piece = 1'b0;
            pieces_due.push_back(o);
            o.out_vertex_a = vv[ins[1]]; o.out_tex_a = tt[ins[1]];
            o.out_vertex_b = cv1;        o.out_tex_b = ct1;
            o.out_vertex_c = blend(vv[ins[1]], vv[outs[0]], t2, 1'b0);
            o.out_tex_c = blend(tt[ins[1]], tt[outs[0]], t2, 1'b1);
            o.piece_index = 1'b1;
            o.last_piece = 1'b1;
            pieces_due.push_back(o);
        end
    endtask

    // Result checker and receiver stalls.
    always @(posedge aclk) begin
        clip_out_t want;
        if (aresetn && m_valid && m_ready) begin
            pieces_seen++;
            if (pieces_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected piece %h", m_data);
            end else begin
                want = pieces_due.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("piece mismatch at %0t", $realtime);
                        $display("  expected %h", want);
                        $display("  actual   %h", m_data);
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid stays high between back-to-back transactions; idle gaps and the
    // drain before a plane change drop it.
    task automatic send_triangle(input clip_in_t trng);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= trng;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pieces(trng);
        tris_sent++;
        @(negedge aclk);
    endtask

    task automatic write_plane_reg(input cfg_reg_t idx, input logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_POINT_X:  plane_pt[0] = val;
            REG_POINT_Y:  plane_pt[1] = val;
            REG_POINT_Z:  plane_pt[2] = val;
            REG_NORMAL_X: plane_nrm[0] = val;
            REG_NORMAL_Y: plane_nrm[1] = val;
            default:      plane_nrm[2] = val;
        endcase
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pieces_due.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic set_plane(input logic [CW-1:0] px, py, pz, nx, ny, nz);
        wait_idle();
        write_plane_reg(REG_POINT_X, px);
        write_plane_reg(REG_POINT_Y, py);
        write_plane_reg(REG_POINT_Z, pz);
        write_plane_reg(REG_NORMAL_X, nx);
        write_plane_reg(REG_NORMAL_Y, ny);
        write_plane_reg(REG_NORMAL_Z, nz);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [47:0] pack_pt(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    // Small coordinates keep cuts near the plane interesting; full range covers extremes.
    function automatic logic [47:0] rand_vertex();
        case ($urandom_range(3))
            0: return rand48();
            1: return pack_pt($urandom_range(65535), $urandom_range(65535),
                              int'($urandom_range(2000)) - 1000);
            default: return pack_pt(int'($urandom_range(4000)) - 2000,
                                    int'($urandom_range(4000)) - 2000,
                                    int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    function automatic clip_in_t rand_triangle();
        clip_in_t t;
        t.vertex_a = rand_vertex(); t.vertex_b = rand_vertex(); t.vertex_c = rand_vertex();
        t.tex_a = rand48(); t.tex_b = rand48(); t.tex_c = rand48();
        t.color = $urandom();
        return t;
    endfunction

    function automatic clip_in_t make_tri(logic [47:0] a, b, c);
        clip_in_t t;
        t.vertex_a = a; t.vertex_b = b; t.vertex_c = c;
        t.tex_a = rand48(); t.tex_b = rand48(); t.tex_c = rand48();
        t.color = $urandom();
        return t;
    endfunction

    // Default plane z = 0: every in/out combination and vertex ordering.
    task automatic test_inside_outside_cases();
        for (int m = 0; m < 8; m++)
            send_triangle(make_tri(pack_pt(10, 20, m[0] ? 64 : -64),
                                   pack_pt(-30, 5, m[1] ? 0 : -1),
                                   pack_pt(7, -9, m[2] ? 32767 : -32768)));
    endtask

    task automatic test_field_extremes();
        clip_in_t t;
        t = '1;
        send_triangle(t);
        t = '0;
        send_triangle(t);
        send_triangle(make_tri(pack_pt(-32768, 32767, 32767),
                               pack_pt(32767, -32768, -32768),
                               pack_pt(0, 0, -32768)));
        send_triangle(make_tri(pack_pt(32767, 32767, 1),
                               pack_pt(-32768, -32768, -32768),
                               pack_pt(32767, -32768, 5)));
    endtask

    task automatic test_zero_normal();
        set_plane(16'h1234, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0);
        repeat (4) send_triangle(rand_triangle());
    endtask

    task automatic test_extreme_planes();
        set_plane(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        repeat (4) send_triangle(rand_triangle());
        set_plane(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        repeat (4) send_triangle(rand_triangle());
    endtask

    task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        case ($urandom_range(2))
            0: set_plane(CW'($urandom()), CW'($urandom()), CW'($urandom()),
                         CW'($urandom()), CW'($urandom()), CW'($urandom()));
            1: set_plane(CW'(int'($urandom_range(400)) - 200),
                         CW'(int'($urandom_range(400)) - 200),
                         CW'(int'($urandom_range(400)) - 200),
                         CW'(int'($urandom_range(256)) - 128),
                         CW'(int'($urandom_range(256)) - 128),
                         CW'(int'($urandom_range(256)) - 128));
            default: set_plane('0, '0, CW'(int'($urandom_range(200)) - 100),
                               '0, '0, CW'(NORMAL_Z_RESET));
        endcase
        repeat (n) send_triangle(rand_triangle());
    endtask

    initial begin
        plane_pt[0] = '0; plane_pt[1] = '0; plane_pt[2] = '0;
        plane_nrm[0] = '0; plane_nrm[1] = '0; plane_nrm[2] = CW'(NORMAL_Z_RESET);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_inside_outside_cases();
        test_field_extremes();
        test_zero_normal();
        test_extreme_planes();

        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: random_phase(115, 0, 0);
                1: random_phase(115, 51, 0);
                2: random_phase(115, 0, 51);
                default: random_phase(115, 30, 30);
            endcase
        end

        wait_idle();
        $display("Sent %0d triangles over %0d plane settings; %0d pieces checked,",
                 tris_sent, 20, pieces_seen);
        $display("%0d triangles split in two, %0d fully clipped, %0d mismatches.",
                 split_count, drop_count, mismatches);
        if (mismatches == 0 && pieces_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
